// ===== sv/tlr_pkg.sv =====
package tlr_pkg;

	// Default widths of the coordinate, width and fraction fields.
	localparam int COORD_BITS_DEF = 12;
	localparam int WIDTH_BITS_DEF = 8;
	localparam int FRAC_BITS_DEF  = 16;

	// Fixed widths of the result fields.
	localparam int PIX_BITS   = 14;
	localparam int COLOR_BITS = 24;
	localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'hFFFFFF;

	// Request kinds carried on tuser.
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_CHECK,
		ST_DIVX,
		ST_LOADY,
		ST_DIVY,
		ST_MUL,
		ST_SUM,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic sqrt_step;
		logic div_load;
		logic div_step;
		logic div_last;
		logic axis_y;
		logic mul;
		logic sum;
		logic tick;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero;
		logic strand_end;
		logic line_end;
		logic out_full;
	} stat_t;

endpackage

// ===== sv/tlr_ctrl.sv =====
module tlr_ctrl #(
	parameter int ROOT_BITS = tlr_pkg::COORD_BITS_DEF + 1 + tlr_pkg::FRAC_BITS_DEF,
	parameter int QUOT_BITS = tlr_pkg::FRAC_BITS_DEF + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_op,
	input  tlr_pkg::stat_t  stat,
	output logic            s_tready,
	output tlr_pkg::cmd_t   cmd,
	output tlr_pkg::state_t state
);

	localparam int CW = $clog2(ROOT_BITS);

	tlr_pkg::state_t state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic            accept;

	assign state  = state_q;
	assign accept = s_tvalid && s_tready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Iteration counter, restarted on every state change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q != state_d) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlr_pkg::ST_IDLE: begin
				if (accept && s_op == tlr_pkg::OP_START) state_d = tlr_pkg::ST_SQRT;
			end
			tlr_pkg::ST_SQRT: begin
				if (cnt_q == CW'(ROOT_BITS - 1)) state_d = tlr_pkg::ST_CHECK;
			end
			tlr_pkg::ST_CHECK: begin
				state_d = stat.zero ? tlr_pkg::ST_IDLE : tlr_pkg::ST_DIVX;
			end
			tlr_pkg::ST_DIVX: begin
				if (cnt_q == CW'(QUOT_BITS - 1)) state_d = tlr_pkg::ST_LOADY;
			end
			tlr_pkg::ST_LOADY: state_d = tlr_pkg::ST_DIVY;
			tlr_pkg::ST_DIVY: begin
				if (cnt_q == CW'(QUOT_BITS - 1)) state_d = tlr_pkg::ST_MUL;
			end
			tlr_pkg::ST_MUL: state_d = tlr_pkg::ST_SUM;
			tlr_pkg::ST_SUM: state_d = tlr_pkg::ST_RUN;
			tlr_pkg::ST_RUN: begin
				if (accept && s_op == tlr_pkg::OP_START) begin
					state_d = tlr_pkg::ST_SQRT;
				end else if (accept && stat.line_end) begin
					state_d = tlr_pkg::ST_IDLE;
				end
			end
			default: state_d = tlr_pkg::ST_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		s_tready = (state_q == tlr_pkg::ST_IDLE || state_q == tlr_pkg::ST_RUN)
			&& !stat.out_full;
		cmd           = '0;
		cmd.start     = accept && s_op == tlr_pkg::OP_START;
		cmd.tick      = accept && s_op == tlr_pkg::OP_TICK && state_q == tlr_pkg::ST_RUN;
		cmd.sqrt_step = state_q == tlr_pkg::ST_SQRT;
		cmd.div_load  = (state_q == tlr_pkg::ST_CHECK && !stat.zero)
			|| state_q == tlr_pkg::ST_LOADY;
		cmd.axis_y    = state_q == tlr_pkg::ST_LOADY || state_q == tlr_pkg::ST_DIVY;
		cmd.div_step  = state_q == tlr_pkg::ST_DIVX || state_q == tlr_pkg::ST_DIVY;
		cmd.div_last  = cmd.div_step && cnt_q == CW'(QUOT_BITS - 1);
		cmd.mul       = state_q == tlr_pkg::ST_MUL;
		cmd.sum       = state_q == tlr_pkg::ST_SUM;
	end

endmodule

// ===== sv/tlr_dp.sv =====
module tlr_dp #(
	parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
	parameter int WIDTH_BITS = tlr_pkg::WIDTH_BITS_DEF,
	parameter int FRAC_BITS  = tlr_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tlr_pkg::cmd_t                   cmd,
	input  logic [COORD_BITS-1:0]           start_x,
	input  logic [COORD_BITS-1:0]           start_y,
	input  logic [COORD_BITS-1:0]           end_x,
	input  logic [COORD_BITS-1:0]           end_y,
	input  logic [WIDTH_BITS-1:0]           strand_count,
	input  logic [tlr_pkg::COLOR_BITS-1:0]  color_in,
	input  logic                            m_tready,
	output tlr_pkg::stat_t                  stat,
	output logic                            m_tvalid,
	output logic [tlr_pkg::PIX_BITS-1:0]    pixel_x,
	output logic [tlr_pkg::PIX_BITS-1:0]    pixel_y,
	output logic [tlr_pkg::COLOR_BITS-1:0]  color,
	output logic                            last
);

	localparam int C  = COORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int RB = C + 1 + F;          // root bits
	localparam int QB = F + 1;              // quotient bits
	localparam int UB = F + 2;              // signed unit vector bits
	localparam int NB = C + 2 * F + 1;      // divider numerator bits
	localparam int PW = C + F + 3;          // signed position bits
	localparam int PL = RB + 1 + UB;        // length times unit product
	localparam int PO = WIDTH_BITS + 1 + UB; // offset times unit product
	localparam int EW = PW + PO;
	localparam int SB = 2 * C + 1;          // squared length bits

	// Line setup registers.
	logic [C-1:0]           anchor_x_q, anchor_y_q, mag_x_q, mag_y_q;
	logic                   neg_x_q, neg_y_q;
	logic [WIDTH_BITS-1:0]  w_q, strands_q;
	logic [2*RB-1:0]        rad_q;
	logic [RB-1:0]          root_q;
	logic [RB+1:0]          rem_q;
	logic [NB-1:0]          drem_q, ddiv_q;
	logic [QB-1:0]          quot_q;
	logic signed [UB-1:0]   unit_x_q, unit_y_q;
	logic signed [PL-1:0]   plx_q, ply_q;
	logic signed [PO-1:0]   ofx_q, ofy_q;
	logic signed [PW-1:0]   strand_x_q, strand_y_q, point_x_q, point_y_q;
	logic [C:0]             steps_q;
	logic                   out_valid_q;

	// Start: differences and squared length.
	logic signed [C:0] dx, dy;
	logic [C-1:0]      mx, my;
	logic [SB-1:0]     sq;
	always_comb begin
		dx = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
		dy = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
		mx = dx[C] ? C'(-dx) : dx[C-1:0];
		my = dy[C] ? C'(-dy) : dy[C-1:0];
		sq = SB'(mx) * SB'(mx) + SB'(my) * SB'(my);
	end

	// One root bit per step.
	logic [RB+1:0] rem_sh, trial;
	logic          sq_ge;
	always_comb begin
		rem_sh = {rem_q[RB-1:0], rad_q[2*RB-1 -: 2]};
		trial  = {root_q, 2'b01};
		sq_ge  = rem_sh >= trial;
	end

	// One quotient bit per step, rounded on the numerator.
	logic [C-1:0]         dmag;
	logic                 dneg, dv_ge;
	logic [QB-1:0]        qn;
	logic signed [UB-1:0] unit_new;
	always_comb begin
		dmag     = cmd.axis_y ? mag_y_q : mag_x_q;
		dneg     = cmd.axis_y ? neg_y_q : neg_x_q;
		dv_ge    = drem_q >= ddiv_q;
		qn       = {quot_q[QB-2:0], dv_ge};
		unit_new = dneg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
	end

	// Start offset of the first strand.
	logic signed [WIDTH_BITS:0] off0;
	assign off0 = -$signed({2'b00, w_q[WIDTH_BITS-1:1]});

	// Rounded length-times-unit terms and strand start sums.
	logic [PL-1:0]        mgx, mgy, rx, ry;
	logic signed [PW-1:0] rnd_x, rnd_y, ax, ay, sx, sy;
	logic signed [EW-1:0] ofx_e, ofy_e;
	always_comb begin
		mgx   = plx_q[PL-1] ? PL'(-plx_q) : PL'(plx_q);
		mgy   = ply_q[PL-1] ? PL'(-ply_q) : PL'(ply_q);
		rx    = (mgx + (PL'(1) << (F - 1))) >> F;
		ry    = (mgy + (PL'(1) << (F - 1))) >> F;
		rnd_x = plx_q[PL-1] ? -$signed(rx[PW-1:0]) : $signed(rx[PW-1:0]);
		rnd_y = ply_q[PL-1] ? -$signed(ry[PW-1:0]) : $signed(ry[PW-1:0]);
		ax    = $signed({{(PW-C-F){1'b0}}, anchor_x_q, {F{1'b0}}});
		ay    = $signed({{(PW-C-F){1'b0}}, anchor_y_q, {F{1'b0}}});
		ofx_e = EW'(ofx_q);
		ofy_e = EW'(ofy_q);
		sx    = ax + rnd_x + $signed(ofx_e[PW-1:0]);
		sy    = ay + rnd_y - $signed(ofy_e[PW-1:0]);
	end

	// Unit vector at position width, and the next strand starts.
	logic signed [PW-1:0] ux_e, uy_e, nsx, nsy;
	always_comb begin
		ux_e = PW'(unit_x_q);
		uy_e = PW'(unit_y_q);
		nsx  = strand_x_q + uy_e;
		nsy  = strand_y_q - ux_e;
	end

	// Pixel rounding of the current point.
	logic [PW-1:0]        pmx, pmy, prx, pry;
	logic signed [PW-1:0] pvx, pvy;
	always_comb begin
		pmx = point_x_q[PW-1] ? PW'(-point_x_q) : PW'(point_x_q);
		pmy = point_y_q[PW-1] ? PW'(-point_y_q) : PW'(point_y_q);
		prx = (pmx + (PW'(1) << (F - 1))) >> F;
		pry = (pmy + (PW'(1) << (F - 1))) >> F;
		pvx = point_x_q[PW-1] ? -$signed(prx) : $signed(prx);
		pvy = point_y_q[PW-1] ? -$signed(pry) : $signed(pry);
	end

	// Setup registers: root, division, products.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			anchor_x_q <= start_x;
			anchor_y_q <= start_y;
			mag_x_q    <= mx;
			mag_y_q    <= my;
			neg_x_q    <= dx[C];
			neg_y_q    <= dy[C];
			w_q        <= strand_count;
			rad_q      <= {(2*RB-SB-2*F)'(0), sq, {(2*F){1'b0}}};
			root_q     <= '0;
			rem_q      <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[RB-2:0], sq_ge};
		end
		if (cmd.div_load) begin
			drem_q <= {1'b0, dmag, {(2*F){1'b0}}} + NB'(root_q >> 1);
			ddiv_q <= NB'(root_q) << (QB - 1);
			quot_q <= '0;
		end else if (cmd.div_step) begin
			drem_q <= dv_ge ? drem_q - ddiv_q : drem_q;
			ddiv_q <= ddiv_q >> 1;
			quot_q <= qn;
		end
		if (cmd.div_last && !cmd.axis_y) unit_x_q <= unit_new;
		if (cmd.div_last && cmd.axis_y)  unit_y_q <= unit_new;
		if (cmd.mul) begin
			plx_q <= $signed({1'b0, root_q}) * unit_x_q;
			ply_q <= $signed({1'b0, root_q}) * unit_y_q;
			ofx_q <= off0 * unit_y_q;
			ofy_q <= off0 * unit_x_q;
		end
	end

	// Walk registers: strand starts, point and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q   <= '0;
			strands_q <= '0;
		end else if (cmd.sum) begin
			steps_q   <= root_q[RB-1:F];
			strands_q <= w_q;
		end else if (cmd.tick) begin
			if (steps_q == (C+1)'(1)) begin
				steps_q   <= root_q[RB-1:F];
				strands_q <= strands_q - 1'b1;
			end else begin
				steps_q <= steps_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			strand_x_q <= sx;
			strand_y_q <= sy;
			point_x_q  <= sx;
			point_y_q  <= sy;
		end else if (cmd.tick) begin
			if (steps_q == (C+1)'(1)) begin
				strand_x_q <= nsx;
				strand_y_q <= nsy;
				point_x_q  <= nsx;
				point_y_q  <= nsy;
			end else begin
				point_x_q <= point_x_q - ux_e;
				point_y_q <= point_y_q - uy_e;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.tick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			pixel_x <= pvx[tlr_pkg::PIX_BITS-1:0];
			pixel_y <= pvy[tlr_pkg::PIX_BITS-1:0];
			color   <= color_in;
			last    <= stat.line_end;
		end
	end

	// Status.
	always_comb begin
		stat.zero       = root_q == '0 || w_q == '0;
		stat.strand_end = steps_q == (C+1)'(1);
		stat.line_end   = stat.strand_end && strands_q == WIDTH_BITS'(1);
		stat.out_full   = out_valid_q && !m_tready;
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== sv/thick_line_rasterizer_unit.sv =====
// Thick line rasterizer. A start request (tuser 0) takes two endpoints and a
// width; the block then computes the length with a bit-serial square root
// (one result bit per cycle) and both unit vector components with a shared
// restoring divider (one quotient bit per cycle), then multiply and sum.
// A start stalls the input while the block works out the root bits
// (COORD_BITS+FRAC_BITS+1), two quotients of FRAC_BITS+1 bits each, and the
// check, load, multiply and sum steps. After that, tick requests (tuser 1)
// are taken one per cycle, each giving one pixel, while the result side keeps
// taking them. Strands follow each other with no gap; tlast marks the last
// pixel of the whole line. A zero length or zero width line gives no pixels,
// and ticks while idle are taken and dropped. The block leaves it to the user
// to set the pixel color through cfg_we/cfg_wdata only while the block is idle.
module thick_line_rasterizer_unit #(
	parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
	parameter int WIDTH_BITS = tlr_pkg::WIDTH_BITS_DEF,
	parameter int FRAC_BITS  = tlr_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// start_x, start_y, end_x, end_y, strand_count from bit 0 up, zero filled
	input  logic [((4*COORD_BITS+WIDTH_BITS+7)/8)*8-1:0] s_tdata,
	// op
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// pixel_x, pixel_y, color from bit 0 up, zero filled
	output logic [((2*tlr_pkg::PIX_BITS+tlr_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [tlr_pkg::COLOR_BITS-1:0] cfg_wdata
);

	localparam int C      = COORD_BITS;
	localparam int OUT_DW = ((2*tlr_pkg::PIX_BITS+tlr_pkg::COLOR_BITS+7)/8)*8;
	localparam int OUT_US = 2*tlr_pkg::PIX_BITS+tlr_pkg::COLOR_BITS;

	logic [tlr_pkg::COLOR_BITS-1:0] color_q, color;
	logic [tlr_pkg::PIX_BITS-1:0]   pixel_x, pixel_y;
	tlr_pkg::cmd_t                  cmd;
	tlr_pkg::stat_t                 stat;
	tlr_pkg::state_t                state;

	// Color register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tlr_pkg::COLOR_RESET;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	tlr_ctrl #(
		.ROOT_BITS(COORD_BITS + 1 + FRAC_BITS),
		.QUOT_BITS(FRAC_BITS + 1)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_op    (s_tuser),
		.stat    (stat),
		.s_tready(s_tready),
		.cmd     (cmd),
		.state   (state)
	);

	tlr_dp #(
		.COORD_BITS(COORD_BITS),
		.WIDTH_BITS(WIDTH_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.start_x     (s_tdata[C-1:0]),
		.start_y     (s_tdata[2*C-1:C]),
		.end_x       (s_tdata[3*C-1:2*C]),
		.end_y       (s_tdata[4*C-1:3*C]),
		.strand_count(s_tdata[4*C+WIDTH_BITS-1:4*C]),
		.color_in    (color_q),
		.m_tready    (m_tready),
		.stat        (stat),
		.m_tvalid    (m_tvalid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.color       (color),
		.last        (m_tlast)
	);

	// Result packing.
	assign m_tdata = {(OUT_DW-OUT_US)'(0), color, pixel_y, pixel_x};

	// Setup states never take requests.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(state == tlr_pkg::ST_IDLE || state == tlr_pkg::ST_RUN) |-> !s_tready)
		else $error("request taken during line setup");

	// A tick taken while walking gives a result in the next cycle.
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == tlr_pkg::OP_TICK
			&& state == tlr_pkg::ST_RUN |=> m_tvalid)
		else $error("tick lost");

	// An empty line returns to idle right after the root.
	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state == tlr_pkg::ST_CHECK && stat.zero |=> state == tlr_pkg::ST_IDLE)
		else $error("empty line did not return to idle");

endmodule

// ===== sim/tlr_checker.sv =====
// Watches both streams and the color port of the rasterizer, predicts every
// pixel and compares each pixel request that leaves the block.
module tlr_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [55:0] s_tdata,
	input  logic s_tuser,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [55:0] m_tdata,
	input  logic m_tlast,
	input  logic cfg_we,
	input  logic [tlr_pkg::COLOR_BITS-1:0] cfg_wdata,
	output int errors,
	output int pending,
	output int pixels_seen,
	output logic line_active
);

	localparam int FB = tlr_pkg::FRAC_BITS_DEF;

	typedef struct {
		logic [tlr_pkg::PIX_BITS-1:0] x;
		logic [tlr_pkg::PIX_BITS-1:0] y;
		logic [tlr_pkg::COLOR_BITS-1:0] c;
		logic l;
	} pixel_t;

	pixel_t pixel_q[$];

	// Shadow copy of the line walker.
	logic [tlr_pkg::COLOR_BITS-1:0] color_reg = tlr_pkg::COLOR_RESET;
	longint unit_dx, unit_dy, len_fx, pos_x, pos_y;
	int steps, strands, offset;
	int org_x, org_y;
	bit walking = 0;

	assign pending = pixel_q.size();
	assign line_active = walking;

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// Drops FB fraction bits, rounding half away from zero.
	function automatic longint round_frac(longint v);
		longint half;
		half = longint'(1) << (FB - 1);
		if (v < 0) return -((-v + half) >>> FB);
		return (v + half) >>> FB;
	endfunction

	function automatic longint unit_part(longint d, longint len);
		longint m, q;
		m = d < 0 ? -d : d;
		q = ((m << (2 * FB)) + len / 2) / len;
		return d < 0 ? -q : q;
	endfunction

	function automatic void start_strand();
		pos_x = (longint'(org_x) << FB) + longint'(offset) * unit_dy
			+ round_frac(len_fx * unit_dx);
		pos_y = (longint'(org_y) << FB) - longint'(offset) * unit_dx
			+ round_frac(len_fx * unit_dy);
		steps = int'(len_fx >> FB);
	endfunction

	function automatic void take_line(logic [55:0] d);
		longint dx, dy;
		int w;
		org_x = d[11:0];
		org_y = d[23:12];
		dx = longint'(d[35:24]) - org_x;
		dy = longint'(d[47:36]) - org_y;
		w = d[55:48];
		walking = 0;
		len_fx = root_floor((dx * dx + dy * dy) << (2 * FB));
		unit_dx = 0;
		unit_dy = 0;
		if (len_fx == 0 || w == 0) return;
		unit_dx = unit_part(dx, len_fx);
		unit_dy = unit_part(dy, len_fx);
		strands = w;
		offset = -(w / 2);
		start_strand();
		walking = steps != 0;
	endfunction

	function automatic void take_tick();
		pixel_t p;
		if (!walking) return;
		p.x = tlr_pkg::PIX_BITS'(round_frac(pos_x));
		p.y = tlr_pkg::PIX_BITS'(round_frac(pos_y));
		p.c = color_reg;
		p.l = 0;
		pos_x -= unit_dx;
		pos_y -= unit_dy;
		steps--;
		if (steps == 0) begin
			strands--;
			if (strands == 0) begin
				walking = 0;
				p.l = 1;
			end else begin
				offset++;
				start_strand();
			end
		end
		pixel_q.push_back(p);
	endfunction

	initial errors = 0;
	initial pixels_seen = 0;

	// Predict on every accepted request, compare every accepted pixel.
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				pixels_seen++;
				if (pixel_q.size() == 0) begin
					errors++;
					$display("%0t: pixel x=%0d y=%0d with none expected", $time,
						$signed(m_tdata[13:0]), $signed(m_tdata[27:14]));
				end else begin
					e = pixel_q.pop_front();
					if (e.x !== m_tdata[13:0] || e.y !== m_tdata[27:14]
						|| e.c !== m_tdata[51:28] || e.l !== m_tlast) begin
						errors++;
						$display("%0t: expected x=%0d y=%0d color=%h last=%b", $time,
							$signed(e.x), $signed(e.y), e.c, e.l);
						$display("%0t:   actual x=%0d y=%0d color=%h last=%b", $time,
							$signed(m_tdata[13:0]), $signed(m_tdata[27:14]),
							m_tdata[51:28], m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == tlr_pkg::OP_START) take_line(s_tdata);
				else take_tick();
			end
			if (cfg_we) color_reg = cfg_wdata;
		end
	end
endmodule

// ===== sim/tb_top.sv =====
module tb_top;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [55:0] s_tdata = '0;
	logic s_tuser = tlr_pkg::OP_TICK;
	logic m_tvalid;
	logic m_tready = 0;
	logic [55:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 0;
	logic [tlr_pkg::COLOR_BITS-1:0] cfg_wdata = '0;

	int errors, pending, pixels_seen;
	logic line_active;
	int requests = 0, lines = 0, color_writes = 0;
	int stall_left = 0;
	bit no_gaps = 0;
	int quiet = 0;

	always #5 clk = ~clk;

	thick_line_rasterizer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	tlr_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending), .pixels_seen(pixels_seen),
		.line_active(line_active)
	);

	// Pixel side stalls: mostly short, a few long, none while no_gaps is set.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 0;
		end else if (!no_gaps && $urandom_range(0, 99) < 15) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	// Watchdog on cycles with no request moving on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= 3000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push(input logic op, input logic [55:0] d);
		int gap;
		gap = 0;
		if (!no_gaps) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gap = $urandom_range(1, 3);
				3: gap = $urandom_range(5, 30);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= d;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		requests++;
	endtask

	task automatic tick();
		push(tlr_pkg::OP_TICK, 56'({$urandom, $urandom}));
	endtask

	task automatic line(input int sx, sy, ex, ey, w);
		push(tlr_pkg::OP_START, {8'(w), 12'(ey), 12'(ex), 12'(sy), 12'(sx)});
		lines++;
	endtask

	// Finish any open line, then let every pixel drain and the block go idle.
	task automatic drain();
		while (line_active) tick();
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	task automatic set_color(input logic [tlr_pkg::COLOR_BITS-1:0] c);
		cfg_we <= 1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 0;
		color_writes++;
	endtask

	function automatic int len_floor(int dx, int dy);
		int s, k;
		s = dx * dx + dy * dy;
		k = 0;
		while ((k + 1) * (k + 1) <= s) k++;
		return k;
	endfunction

	initial begin
		int sx, sy, ex, ey, dx, dy, w, n, pick;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: idle tick, zero length, zero width, extremes, restart while busy.
		tick();
		line(100, 100, 100, 100, 5);
		line(0, 0, 10, 0, 0);
		tick();
		line(0, 0, 4095, 4095, 255);
		repeat (3) tick();
		line(4095, 4095, 4092, 4091, 2);
		repeat (11) tick();
		line(4095, 0, 0, 4095, 1);
		repeat (2) tick();
		line(2000, 2000, 2003, 2000, 3);
		repeat (9) tick();
		drain();
		set_color('0);
		line(10, 10, 10, 13, 1);
		repeat (3) tick();
		drain();
		set_color(24'hFFFFFF);

		// Random lines, mostly short and complete, some broken off or padded.
		while (requests < 1450) begin
			if (lines % 40 == 0) begin
				drain();
				set_color(24'($urandom));
			end
			if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
			pick = $urandom_range(0, 99);
			sx = $urandom_range(0, 4095);
			sy = $urandom_range(0, 4095);
			if (pick < 5) begin
				dx = $urandom_range(0, 4095) - 2048;
				dy = $urandom_range(0, 4095) - 2048;
				w = $urandom_range(1, 255);
			end else if (pick < 10) begin
				dx = $urandom_range(0, 1) * $urandom_range(0, 3);
				dy = 0;
				w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
			end else if (pick < 12) begin
				dx = 1;
				dy = 0;
				w = $urandom_range(128, 255);
			end else if (pick < 25) begin
				dx = $urandom_range(0, 4) - 2;
				dy = $urandom_range(0, 4) - 2;
				w = $urandom_range(5, 40);
			end else begin
				dx = $urandom_range(0, 14) - 7;
				dy = $urandom_range(0, 14) - 7;
				w = $urandom_range(1, 4);
			end
			ex = (sx + dx > 4095 || sx + dx < 0) ? sx - dx : sx + dx;
			ey = (sy + dy > 4095 || sy + dy < 0) ? sy - dy : sy + dy;
			line(sx, sy, ex, ey, w);
			n = len_floor(ex - sx, ey - sy) * w;
			if (pick < 5) n = $urandom_range(0, 20);
			else if ($urandom_range(0, 9) == 0) n = n - $urandom_range(0, n);
			else if ($urandom_range(0, 9) == 0) n = n + $urandom_range(1, 3);
			repeat (n) tick();
		end

		drain();
		$display("Covered %0d lines in %0d requests with %0d pixels checked", lines,
			requests, pixels_seen);
		$display("and %0d color writes, under random stalls on both sides.", color_writes);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
